@@ rtl/fhcc_pkg.sv @@
// Package for the flash/hit coincidence classifier.
// Holds command and register codes, the queued operation type and the
// pattern classification function. Depends on nothing.
`default_nettype none

package fhcc_pkg;

   // Default time width and fixed field widths.
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int CMD_BITS          = 2;
   localparam int PLANE_BITS        = 7;
   localparam int WINDOW_BITS       = 16;
   localparam int CLASS_BITS        = 4;
   localparam int COUNT_BITS        = 2;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [PLANE_BITS-1:0]  SIDE_PLANE_LIMIT = 7'd36;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX        = 2'd2;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET     = 16'd100;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_HIT    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FINISH = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_FIRST = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW    = 1'd1;

   // Pattern codes.
   localparam logic [CLASS_BITS-1:0] CLASS_NONE           = 4'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_TOP_ENTER      = 4'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_SIDE_ENTER     = 4'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_TOP_ENTER_SIDE_EXIT = 4'd3;
   localparam logic [CLASS_BITS-1:0] CLASS_TOP_EXIT       = 4'd4;
   localparam logic [CLASS_BITS-1:0] CLASS_SIDE_EXIT      = 4'd5;
   localparam logic [CLASS_BITS-1:0] CLASS_BOTH_ENTER     = 4'd6;
   localparam logic [CLASS_BITS-1:0] CLASS_BOTH_ENTER_SIDE_EXIT = 4'd7;
   localparam logic [CLASS_BITS-1:0] CLASS_OTHER          = 4'd8;

   typedef enum logic [1:0] {
      OP_START,
      OP_HIT,
      OP_FINISH
   } op_kind_type;

   // Which counter a hit bumps; all zero when the hit falls outside the window.
   typedef struct packed {
      logic top_enter;
      logic side_enter;
      logic top_exit;
      logic side_exit;
   } hit_bucket_type;

   typedef struct packed {
      op_kind_type    kind;
      hit_bucket_type bucket;
   } op_type;

   function automatic logic [CLASS_BITS-1:0] classify(
      input logic [COUNT_BITS-1:0] te,
      input logic [COUNT_BITS-1:0] se,
      input logic [COUNT_BITS-1:0] tx,
      input logic [COUNT_BITS-1:0] sx
   );
      logic te0, se0, tx0, sx0, te1, se1, tx1, sx1;
      logic [CLASS_BITS-1:0] code;
      te0 = (te == '0);
      se0 = (se == '0);
      tx0 = (tx == '0);
      sx0 = (sx == '0);
      te1 = (te == COUNT_BITS'(1));
      se1 = (se == COUNT_BITS'(1));
      tx1 = (tx == COUNT_BITS'(1));
      sx1 = (sx == COUNT_BITS'(1));
      if (te0 && se0 && tx0 && sx0)            code = CLASS_NONE;
      else if (te1 && se0 && tx0 && sx0)       code = CLASS_TOP_ENTER;
      else if (te0 && se1 && tx0 && sx0)       code = CLASS_SIDE_ENTER;
      else if (te1 && se0 && tx0 && sx1)       code = CLASS_TOP_ENTER_SIDE_EXIT;
      else if (te0 && se0 && tx1 && sx0)       code = CLASS_TOP_EXIT;
      else if (te0 && se0 && tx0 && sx1)       code = CLASS_SIDE_EXIT;
      else if (!te0 && !se0 && tx0 && sx0)     code = CLASS_BOTH_ENTER;
      else if (!te0 && !se0 && tx0 && !sx0)    code = CLASS_BOTH_ENTER_SIDE_EXIT;
      else                                     code = CLASS_OTHER;
      return code;
   endfunction

   function automatic logic is_entering_class(input logic [CLASS_BITS-1:0] code);
      return (code == CLASS_TOP_ENTER) || (code == CLASS_SIDE_ENTER) ||
             (code == CLASS_TOP_ENTER_SIDE_EXIT) || (code == CLASS_BOTH_ENTER) ||
             (code == CLASS_BOTH_ENTER_SIDE_EXIT);
   endfunction

endpackage

`default_nettype wire

@@ rtl/fhcc_queue.sv @@
// Short queue of classified operations between the front and back parts.
// Depends on fhcc_pkg for the operation type and depth.
`default_nettype none

module fhcc_queue
   import fhcc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_valid,
   output logic        push_ready,
   input  wire op_type push_data,
   output logic        pop_valid,
   input  wire logic   pop_ready,
   output op_type      pop_data
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

   op_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fhcc_front.sv @@
// Front part: holds the registers and the latched flash time, accepts items
// and turns each known command into a queued operation. Depends on fhcc_pkg.
`default_nettype none

module fhcc_front
   import fhcc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [CMD_BITS-1:0]       req_cmd,
   input  wire logic [TIME_BITS-1:0]      req_flash_time,
   input  wire logic [PLANE_BITS-1:0]     req_hit_plane,
   input  wire logic [TIME_BITS-1:0]      req_hit_time_first,
   input  wire logic [TIME_BITS-1:0]      req_hit_time_second,
   output logic                           push_valid,
   input  wire logic                      push_ready,
   output op_type                         push_data
);

   localparam int DIFF_BITS = TIME_BITS + 1;

   logic                   use_first_ff, use_first_in;
   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [TIME_BITS-1:0]   flash_ff, flash_in;

   logic                   accept;
   logic [TIME_BITS-1:0]   hit_time;
   logic [DIFF_BITS-1:0]   diff_fwd, diff_rev, magnitude;
   logic                   negative, side, in_window;
   hit_bucket_type         bucket;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // Offset is formed one bit wider than the times so it never wraps.
   always_comb begin
      hit_time  = use_first_ff ? req_hit_time_first : req_hit_time_second;
      diff_fwd  = {hit_time[TIME_BITS-1], hit_time} - {flash_ff[TIME_BITS-1], flash_ff};
      diff_rev  = {flash_ff[TIME_BITS-1], flash_ff} - {hit_time[TIME_BITS-1], hit_time};
      negative  = diff_fwd[DIFF_BITS-1];
      magnitude = negative ? diff_rev : diff_fwd;
      in_window = magnitude < {{(DIFF_BITS-WINDOW_BITS){1'b0}}, window_ff};
      side      = req_hit_plane > SIDE_PLANE_LIMIT;
      bucket.top_enter  = in_window && negative && !side;
      bucket.side_enter = in_window && negative && side;
      bucket.top_exit   = in_window && !negative && !side;
      bucket.side_exit  = in_window && !negative && side;
   end

   always_comb begin
      push_valid       = 1'b0;
      push_data.kind   = OP_START;
      push_data.bucket = '0;
      unique case (req_cmd)
         CMD_START: begin
            push_valid = req_valid;
         end
         CMD_HIT: begin
            push_valid       = req_valid;
            push_data.kind   = OP_HIT;
            push_data.bucket = bucket;
         end
         CMD_FINISH: begin
            push_valid     = req_valid;
            push_data.kind = OP_FINISH;
         end
         default: begin
            // Unknown command is taken and dropped.
            push_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      use_first_in = use_first_ff;
      window_in    = window_ff;
      flash_in     = flash_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_USE_FIRST: use_first_in = csr_wdata[0];
            CSR_WINDOW:    window_in    = csr_wdata[WINDOW_BITS-1:0];
            default:       ;
         endcase
      end
      if (accept && (req_cmd == CMD_START)) begin
         flash_in = req_flash_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_first_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
         flash_ff     <= '0;
      end else begin
         use_first_ff <= use_first_in;
         window_ff    <= window_in;
         flash_ff     <= flash_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fhcc_back.sv @@
// Back part: applies queued operations to the four saturating hit counters
// and registers the pattern code on finish. Depends on fhcc_pkg.
`default_nettype none

module fhcc_back
   import fhcc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire op_type                 pop_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [CLASS_BITS-1:0]       rsp_match_class,
   output logic                        rsp_is_entering
);

   logic [COUNT_BITS-1:0] top_enter_ff, top_enter_in;
   logic [COUNT_BITS-1:0] side_enter_ff, side_enter_in;
   logic [COUNT_BITS-1:0] top_exit_ff, top_exit_in;
   logic [COUNT_BITS-1:0] side_exit_ff, side_exit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CLASS_BITS-1:0] class_ff, class_in;
   logic                  entering_ff, entering_in;
   logic                  out_free, pop;

   function automatic logic [COUNT_BITS-1:0] bump(
      input logic [COUNT_BITS-1:0] count,
      input logic                  hit
   );
      return (hit && (count < COUNT_MAX)) ? count + COUNT_BITS'(1) : count;
   endfunction

   // The output register can be loaded when empty or emptied in this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (pop_data.kind != OP_FINISH) || out_free;
   assign pop       = pop_valid && pop_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_class = class_ff;
   assign rsp_is_entering = entering_ff;

   always_comb begin
      top_enter_in  = top_enter_ff;
      side_enter_in = side_enter_ff;
      top_exit_in   = top_exit_ff;
      side_exit_in  = side_exit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      class_in      = class_ff;
      entering_in   = entering_ff;
      if (pop) begin
         unique case (pop_data.kind)
            OP_START: begin
               top_enter_in  = '0;
               side_enter_in = '0;
               top_exit_in   = '0;
               side_exit_in  = '0;
            end
            OP_HIT: begin
               top_enter_in  = bump(top_enter_ff, pop_data.bucket.top_enter);
               side_enter_in = bump(side_enter_ff, pop_data.bucket.side_enter);
               top_exit_in   = bump(top_exit_ff, pop_data.bucket.top_exit);
               side_exit_in  = bump(side_exit_ff, pop_data.bucket.side_exit);
            end
            OP_FINISH: begin
               rsp_valid_in = 1'b1;
               class_in     = classify(top_enter_ff, side_enter_ff,
                                       top_exit_ff, side_exit_ff);
               entering_in  = is_entering_class(class_in);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_enter_ff  <= '0;
         side_enter_ff <= '0;
         top_exit_ff   <= '0;
         side_exit_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         top_enter_ff  <= top_enter_in;
         side_enter_ff <= side_enter_in;
         top_exit_ff   <= top_exit_in;
         side_exit_ff  <= side_exit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff    <= class_in;
      entering_ff <= entering_in;
   end

endmodule

`default_nettype wire

@@ rtl/flash_hit_coincidence_classifier.sv @@
// Flash/hit coincidence classifier, top level.
// Throughput: one item per cycle; the front takes an item whenever the two-entry
// queue has room, and the back drains one operation per cycle while no finish waits
// on a full output register. A finish item is queued, then the back classifies it
// and registers the result. Reset clears the registers to their defaults, the flash
// time, the counters and the queue; no clearing pass is needed.
`default_nettype none

module flash_hit_coincidence_classifier
   import fhcc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [CMD_BITS-1:0]       req_cmd,
   input  wire logic [TIME_BITS-1:0]      req_flash_time,
   input  wire logic [PLANE_BITS-1:0]     req_hit_plane,
   input  wire logic [TIME_BITS-1:0]      req_hit_time_first,
   input  wire logic [TIME_BITS-1:0]      req_hit_time_second,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [CLASS_BITS-1:0]          rsp_match_class,
   output logic                           rsp_is_entering
);

   logic   push_valid, push_ready;
   op_type push_data;
   logic   pop_valid, pop_ready;
   op_type pop_data;

   fhcc_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_flash_time      (req_flash_time),
      .req_hit_plane       (req_hit_plane),
      .req_hit_time_first  (req_hit_time_first),
      .req_hit_time_second (req_hit_time_second),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_data           (push_data)
   );

   fhcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fhcc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_class (rsp_match_class),
      .rsp_is_entering (rsp_is_entering)
   );

endmodule

`default_nettype wire
